// ===== rtl/core/soa_pkg.sv =====
// Shared types, register indexes and reset values for the sonar obstacle-avoid sequencer.
package soa_pkg;

  localparam int unsigned CycW   = 19;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned DistW  = 11;
  localparam int unsigned CfgIdxW = 3;

  // cycles * 557 >> 18 approximates the echo distance in cm
  localparam int unsigned DistMulW   = 10;
  localparam logic [DistMulW-1:0] DistMul = 10'd557;
  localparam int unsigned DistShift  = 18;
  localparam int unsigned ProdW      = CycW + DistMulW;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegNearThresh = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFarLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDriveDuty  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStopMs     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReverseMs  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTurnMs     = 3'd5;

  // register reset values
  localparam logic [CycW-1:0]  NearThreshRst = 19'd4703;
  localparam logic [CycW-1:0]  FarLimitRst   = 19'd188091;
  localparam logic [DutyW-1:0] DriveDutyRst  = 8'd150;
  localparam logic [MsW-1:0]   StopMsRst     = 16'd1000;
  localparam logic [MsW-1:0]   ReverseMsRst  = 16'd2000;
  localparam logic [MsW-1:0]   TurnMsRst     = 16'd1000;

  // input beat kinds
  localparam logic KindTick = 1'b0;
  localparam logic KindEcho = 1'b1;

  typedef enum logic [1:0] {
    PH_SENSE   = 2'd0,
    PH_STOP    = 2'd1,
    PH_REVERSE = 2'd2,
    PH_TURN    = 2'd3
  } phase_e;

  typedef struct packed {
    logic            kind;
    logic [CycW-1:0] echo_cycles;
  } in_t;

  typedef struct packed {
    logic             left_forward;
    logic [DutyW-1:0] left_duty;
    logic             right_forward;
    logic [DutyW-1:0] right_duty;
    logic             led_red;
    logic             led_green;
    logic             led_blue;
    phase_e           phase;
    logic [DistW-1:0] distance_cm;
  } out_t;

  typedef struct packed {
    logic [CycW-1:0]  near_threshold_cycles;
    logic [CycW-1:0]  far_limit_cycles;
    logic [DutyW-1:0] drive_duty;
    logic [MsW-1:0]   stop_ms;
    logic [MsW-1:0]   reverse_ms;
    logic [MsW-1:0]   turn_ms;
  } cfg_t;

  // a phase length of zero runs for one tick
  function automatic logic [MsW-1:0] load_time(input logic [MsW-1:0] ms);
    return (ms == '0) ? MsW'(1) : ms;
  endfunction

endpackage

// ===== rtl/core/soa_ctrl.sv =====
// Sequencer state and the single-pass update for one tick or echo beat.
module soa_ctrl import soa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  phase_e           phase_q, phase_d;
  logic [MsW-1:0]   timer_q, timer_d;
  logic [CycW-1:0]  last_q, last_d;
  logic             fwd_q, fwd_d;
  logic             lfwd_q, lfwd_d, rfwd_q, rfwd_d;
  logic [DutyW-1:0] lduty_q, lduty_d, rduty_q, rduty_d;
  logic             red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic [CycW-1:0]  cyc;
  logic             duty_ok;
  logic [ProdW-1:0] prod;

  // next state for the accepted beat
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    last_d  = last_q;
    fwd_d   = fwd_q;
    lfwd_d  = lfwd_q;
    rfwd_d  = rfwd_q;
    lduty_d = lduty_q;
    rduty_d = rduty_q;
    red_d   = red_q;
    green_d = green_q;
    blue_d  = blue_q;
    duty_ok = (cfg_i.drive_duty != '0);
    // implausible readings fall back to the last accepted one
    cyc = (item_i.echo_cycles > cfg_i.far_limit_cycles) ? last_q : item_i.echo_cycles;

    if (step_i) begin
      if (item_i.kind == KindEcho) begin
        if (phase_q == PH_SENSE) begin
          last_d = cyc;
          if (cyc >= cfg_i.near_threshold_cycles) begin
            if (!fwd_q) begin
              green_d = 1'b1;
              fwd_d   = 1'b1;
              if (duty_ok) begin
                lfwd_d  = 1'b1;
                rfwd_d  = 1'b1;
                lduty_d = cfg_i.drive_duty;
                rduty_d = cfg_i.drive_duty;
              end
            end
          end else begin
            green_d = 1'b0;
            red_d   = 1'b1;
            lduty_d = '0;
            rduty_d = '0;
            phase_d = PH_STOP;
            timer_d = load_time(cfg_i.stop_ms);
          end
        end
      end else if (phase_q != PH_SENSE) begin
        if (timer_q > MsW'(1)) begin
          timer_d = timer_q - MsW'(1);
        end else begin
          case (phase_q)
            PH_STOP: begin
              red_d   = 1'b0;
              blue_d  = 1'b1;
              if (duty_ok) begin
                lfwd_d  = 1'b0;
                rfwd_d  = 1'b0;
                lduty_d = cfg_i.drive_duty;
                rduty_d = cfg_i.drive_duty;
              end
              phase_d = PH_REVERSE;
              timer_d = load_time(cfg_i.reverse_ms);
            end
            PH_REVERSE: begin
              red_d   = 1'b1;
              blue_d  = 1'b1;
              if (duty_ok) begin
                lfwd_d  = 1'b0;
                rfwd_d  = 1'b1;
                lduty_d = cfg_i.drive_duty;
                rduty_d = cfg_i.drive_duty;
              end
              phase_d = PH_TURN;
              timer_d = load_time(cfg_i.turn_ms);
            end
            default: begin
              // end of the spin: back to sensing, motors keep the spin command
              red_d   = 1'b0;
              blue_d  = 1'b0;
              fwd_d   = 1'b0;
              phase_d = PH_SENSE;
              timer_d = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SENSE;
      timer_q <= '0;
      last_q  <= '0;
      fwd_q   <= 1'b0;
      lfwd_q  <= 1'b0;
      rfwd_q  <= 1'b0;
      lduty_q <= '0;
      rduty_q <= '0;
      red_q   <= 1'b0;
      green_q <= 1'b0;
      blue_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      last_q  <= last_d;
      fwd_q   <= fwd_d;
      lfwd_q  <= lfwd_d;
      rfwd_q  <= rfwd_d;
      lduty_q <= lduty_d;
      rduty_q <= rduty_d;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  // result beat reflects the state after this beat
  assign prod = ProdW'(last_d) * ProdW'(DistMul);

  always_comb begin
    result_o.left_forward  = lfwd_d;
    result_o.left_duty     = lduty_d;
    result_o.right_forward = rfwd_d;
    result_o.right_duty    = rduty_d;
    result_o.led_red       = red_d;
    result_o.led_green     = green_d;
    result_o.led_blue      = blue_d;
    result_o.phase         = phase_d;
    result_o.distance_cm   = prod[DistShift +: DistW];
  end

endmodule

// ===== rtl/core/sonar_obstacle_avoid_sequencer_top.sv =====
// Top level of the sonar obstacle-avoid sequencer: config registers, core and output buffer.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one beat per
//   event: a millisecond tick (kind 0) or a finished echo measurement in
//   8 MHz cycles (kind 1). Every input beat yields exactly one result beat on
//   the output channel (out_valid_o / out_ready_i / out_data_o) with motor
//   commands, LED levels, the maneuver phase and the distance in cm.
//   Each result is registered into the output register, or into the skid
//   register while a result waits there. Throughput: one beat per cycle
//   while in_ready_o is high; the state update is a single compare, count
//   and small multiply between the state registers and the output register.
//   Stall: a two-entry output buffer (output register plus skid register)
//   keeps taking input while one result waits; in_ready_o drops only when
//   both entries hold results, and no result is lost or repeated.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i;
//   unknown indexes are ignored. Write only while the block idles.
//   Reset: rst_ni clears the sequencer to sensing with motors and LEDs off,
//   last reading 0, and loads the default thresholds, duty and phase times.
module sonar_obstacle_avoid_sequencer_top import soa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CycW-1:0]    cfg_data_i
);

  cfg_t cfg_q;
  out_t result;
  logic push, pop;
  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_threshold_cycles <= NearThreshRst;
      cfg_q.far_limit_cycles      <= FarLimitRst;
      cfg_q.drive_duty            <= DriveDutyRst;
      cfg_q.stop_ms               <= StopMsRst;
      cfg_q.reverse_ms            <= ReverseMsRst;
      cfg_q.turn_ms               <= TurnMsRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegNearThresh: cfg_q.near_threshold_cycles <= cfg_data_i;
        RegFarLimit:   cfg_q.far_limit_cycles      <= cfg_data_i;
        RegDriveDuty:  cfg_q.drive_duty            <= cfg_data_i[DutyW-1:0];
        RegStopMs:     cfg_q.stop_ms               <= cfg_data_i[MsW-1:0];
        RegReverseMs:  cfg_q.reverse_ms            <= cfg_data_i[MsW-1:0];
        RegTurnMs:     cfg_q.turn_ms               <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  soa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (push),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= result;
        end
      end else if (push) begin
        out_q <= result;
      end
    end else if (push) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the skid entry is only ever filled behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output beat");

  // green is never lit during a maneuver
  a_green_off_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.phase != PH_SENSE)) |-> !out_data_o.led_green)
    else $error("green LED on during maneuver");

  // the stop phase always holds both motors at zero duty
  a_stop_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.phase == PH_STOP)) |->
      (out_data_o.left_duty == '0 && out_data_o.right_duty == '0))
    else $error("motor duty nonzero while stopped");

  // a waiting result beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("output beat changed while stalled");

endmodule
